/* sv/assert_macros.svh */
// assertion macros shared by the resampler rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

/* sv/lir_pkg.sv */
// shared constants and types of the linear interpolation resampler
// no dependencies
package lir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 27;
    localparam int LEN_W       = 15;
    localparam int FRAC_W      = 11;
    localparam int FRAC_ONE    = 2048;
    localparam int COUNT_W     = 11;
    localparam int PROD_W      = SAMPLE_W + FRAC_W + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2500);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev_i;
        logic signed [SAMPLE_W-1:0] prev_q;
        logic signed [SAMPLE_W-1:0] cur_i;
        logic signed [SAMPLE_W-1:0] cur_q;
        logic        [FRAC_W-1:0]   frac;
        logic                       block_end;
    } job_t;

endpackage

/* sv/lir_front.sv */
// front end: takes requests, tracks phase and block count, issues interpolation jobs
// depends on lir_pkg and assert_macros.svh
`include "assert_macros.svh"
module lir_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lir_pkg::LEN_W-1:0]      cfg_in_block_len,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_i,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_q,
    output logic                           push,
    output lir_pkg::job_t                  push_job,
    input  logic                           queue_full
);
    import lir_pkg::*;

    logic [LEN_W-1:0]           len_reg;
    logic [LEN_W-1:0]           phase_reg, phase_next;
    logic [COUNT_W-1:0]         out_count_reg, out_count_next;
    logic                       have_prev_reg;
    logic signed [SAMPLE_W-1:0] prev_i_reg, prev_q_reg;
    logic [LEN_W-1:0]           step;
    logic                       accept;
    logic                       emit;

    assign cfg_ready = 1'b1;
    assign s_ready   = !queue_full;
    assign accept    = s_valid && s_ready;

    // rates above one output per input are clamped
    assign step = (len_reg < LEN_W'(FRAC_ONE)) ? LEN_W'(FRAC_ONE) : len_reg;
    assign emit = have_prev_reg && (phase_reg < LEN_W'(FRAC_ONE));

    always_comb begin
        phase_next     = phase_reg;
        out_count_next = out_count_reg;
        if (have_prev_reg) begin
            if (emit) begin
                phase_next     = LEN_W'(phase_reg + step - LEN_W'(FRAC_ONE));
                out_count_next = COUNT_W'(out_count_reg + COUNT_W'(1));
            end else begin
                phase_next = LEN_W'(phase_reg - LEN_W'(FRAC_ONE));
            end
        end
    end

    assign push                = accept && emit;
    assign push_job.prev_i     = prev_i_reg;
    assign push_job.prev_q     = prev_q_reg;
    assign push_job.cur_i      = s_sample_i;
    assign push_job.cur_q      = s_sample_q;
    assign push_job.frac       = phase_reg[FRAC_W-1:0];
    assign push_job.block_end  = &out_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= LEN_RESET;
            phase_reg     <= '0;
            out_count_reg <= '0;
            have_prev_reg <= 1'b0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                len_reg <= cfg_in_block_len;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                out_count_reg <= out_count_next;
                have_prev_reg <= 1'b1;
                prev_i_reg    <= s_sample_i;
                prev_q_reg    <= s_sample_q;
            end
        end
    end

    `ASSERT_CLK(a_phase_idle, !have_prev_reg |-> (phase_reg == '0))
    `ASSERT_CLK(a_count_step,
        push |=> (out_count_reg == COUNT_W'($past(out_count_reg) + COUNT_W'(1))))

endmodule

/* sv/lir_fifo.sv */
// small job queue between the front end and the interpolation datapath
// depends on lir_pkg and assert_macros.svh
`include "assert_macros.svh"
module lir_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lir_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output lir_pkg::job_t  pop_job
);
    import lir_pkg::*;

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = QUEUE_CNT_W'(count_reg + QUEUE_CNT_W'(1));
        end else if (do_pop && !push) begin
            count_next = QUEUE_CNT_W'(count_reg - QUEUE_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= QUEUE_PTR_W'(wr_ptr_reg + QUEUE_PTR_W'(1));
            end
            if (do_pop) begin
                rd_ptr_reg <= QUEUE_PTR_W'(rd_ptr_reg + QUEUE_PTR_W'(1));
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_overflow, push && full)
    `ASSERT_NEVER(a_count_range, count_reg > QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

/* sv/lir_back.sv */
// back end: two-stage interpolation datapath, products then sum into the output register
// depends on lir_pkg and assert_macros.svh
`include "assert_macros.svh"
module lir_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             job_valid,
    input  lir_pkg::job_t                    job,
    output logic                             job_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [lir_pkg::OUT_W-1:0] m_out_i,
    output logic signed [lir_pkg::OUT_W-1:0] m_out_q,
    output logic                             m_block_end
);
    import lir_pkg::*;

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] pa_i_reg, pb_i_reg, pa_q_reg, pb_q_reg;
    logic signed [PROD_W-1:0] pa_i_next, pb_i_next, pa_q_next, pb_q_next;
    logic                     s1_end_reg;
    logic                     m_valid_reg;
    logic signed [OUT_W-1:0]  out_i_reg, out_q_reg;
    logic                     out_end_reg;
    logic [FRAC_W:0]          w_prev;
    logic signed [FRAC_W+1:0] w_prev_s, w_cur_s;
    logic signed [PROD_W-1:0] sum_i, sum_q;
    logic                     s2_ready;
    logic                     s1_ready;

    assign s2_ready = !m_valid_reg || m_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign job_pop  = job_valid && s1_ready;

    // weights 2048-f and f
    assign w_prev   = (FRAC_W+1)'(FRAC_ONE) - {1'b0, job.frac};
    assign w_prev_s = $signed({1'b0, w_prev});
    assign w_cur_s  = $signed({2'b00, job.frac});

    assign pa_i_next = job.prev_i * w_prev_s;
    assign pb_i_next = job.cur_i * w_cur_s;
    assign pa_q_next = job.prev_q * w_prev_s;
    assign pb_q_next = job.cur_q * w_cur_s;

    assign sum_i = pa_i_reg + pb_i_reg;
    assign sum_q = pa_q_reg + pb_q_reg;

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            pa_i_reg   <= pa_i_next;
            pb_i_reg   <= pb_i_next;
            pa_q_reg   <= pa_q_next;
            pb_q_reg   <= pb_q_next;
            s1_end_reg <= job.block_end;
        end
        if (s2_ready) begin
            out_i_reg   <= sum_i[OUT_W-1:0];
            out_q_reg   <= sum_q[OUT_W-1:0];
            out_end_reg <= s1_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= job_valid;
            end
            if (s2_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_i     = out_i_reg;
    assign m_out_q     = out_q_reg;
    assign m_block_end = out_end_reg;

    `ASSERT_CLK(a_pop_loads, job_pop |=> s1_valid_reg)
    `ASSERT_CLK(a_stage_moves, (s1_valid_reg && s2_ready) |=> m_valid_reg)

endmodule

/* sv/linear_interp_resampler_core.sv */
// path: the request that completes a result is accepted into the job queue, then the
//   result passes the product registers and the output register before it is offered
// throughput: one request per cycle unless the queue is full, one result per cycle while
//   m_ready holds; set by front-end accept path and two-stage multiply-add datapath
// reset: synchronous active-low aresetn clears phase, block count, held sample and
//   queue; in_block_len returns to 2500
module linear_interp_resampler_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lir_pkg::LEN_W-1:0]         cfg_in_block_len,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_i,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_q,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [lir_pkg::OUT_W-1:0]  m_out_i,
    output logic signed [lir_pkg::OUT_W-1:0]  m_out_q,
    output logic                              m_block_end
);
    import lir_pkg::*;

    logic push;
    job_t push_job;
    logic queue_full;
    logic pop;
    logic pop_valid;
    job_t pop_job;

    lir_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_in_block_len (cfg_in_block_len),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_i       (s_sample_i),
        .s_sample_q       (s_sample_q),
        .push             (push),
        .push_job         (push_job),
        .queue_full       (queue_full)
    );

    lir_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    lir_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (pop_valid),
        .job         (pop_job),
        .job_pop     (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_i     (m_out_i),
        .m_out_q     (m_out_q),
        .m_block_end (m_block_end)
    );

endmodule

/* dv/tb_linear_interp_resampler_core.sv */
// self-checking testbench for linear_interp_resampler_core: directed and random iq requests
// across several rate settings, checked against an in-bench interpolation predictor
// depends on lir_pkg and linear_interp_resampler_core
module tb_linear_interp_resampler_core;
    import lir_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_ITEMS   = 60;
    localparam int NUM_PHASES    = 9;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_i;
        logic signed [OUT_W-1:0] out_q;
        logic                    block_end;
    } resample_out_t;

    class resample_scoreboard;
        logic [LEN_W-1:0]           block_len;
        logic signed [SAMPLE_W-1:0] last_i;
        logic signed [SAMPLE_W-1:0] last_q;
        logic [LEN_W-1:0]           pos;
        bit                         primed;
        logic [COUNT_W-1:0]         n_out;
        resample_out_t              pending_outs[$];
        int                         errors;
        int                         n_samples;
        int                         n_checked;
        int                         n_block_ends;

        function new();
            block_len    = LEN_RESET;
            last_i       = '0;
            last_q       = '0;
            pos          = '0;
            primed       = 1'b0;
            n_out        = '0;
            errors       = 0;
            n_samples    = 0;
            n_checked    = 0;
            n_block_ends = 0;
        endfunction

        function void set_len(logic [LEN_W-1:0] v);
            block_len = v;
        endfunction

        function int pending();
            return pending_outs.size();
        endfunction

        function logic signed [OUT_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                                logic signed [SAMPLE_W-1:0] b, int f);
            longint r;
            r = longint'(a) * (FRAC_ONE - f) + longint'(b) * f;
            return r[OUT_W-1:0];
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] si,
                                  logic signed [SAMPLE_W-1:0] sq);
            int            stride;
            resample_out_t e;
            stride = (int'(block_len) < FRAC_ONE) ? FRAC_ONE : int'(block_len);
            n_samples++;
            if (!primed) begin
                primed = 1'b1;
            end else if (int'(pos) < FRAC_ONE) begin
                e.out_i     = blend(last_i, si, int'(pos));
                e.out_q     = blend(last_q, sq, int'(pos));
                e.block_end = (n_out == '1);
                if (e.block_end)
                    n_block_ends++;
                n_out = n_out + 1'b1;
                pos   = LEN_W'(int'(pos) + stride - FRAC_ONE);
                pending_outs.push_back(e);
            end else begin
                pos = LEN_W'(int'(pos) - FRAC_ONE);
            end
            last_i = si;
            last_q = sq;
        endfunction

        function void flag(string what, resample_out_t want, resample_out_t got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: %s exp i=%0d q=%0d end=%0b got i=%0d q=%0d end=%0b",
                         what, want.out_i, want.out_q, want.block_end,
                         got.out_i, got.out_q, got.block_end);
        endfunction

        function void check_result(logic signed [OUT_W-1:0] oi, logic signed [OUT_W-1:0] oq,
                                   logic be);
            resample_out_t got;
            resample_out_t want;
            got.out_i     = oi;
            got.out_q     = oq;
            got.block_end = be;
            if (pending_outs.size() == 0) begin
                flag("result with nothing pending", '0, got);
            end else begin
                want = pending_outs.pop_front();
                n_checked++;
                if (got.out_i !== want.out_i || got.out_q !== want.out_q ||
                    got.block_end !== want.block_end)
                    flag("result fields", want, got);
            end
        endfunction
    endclass

    logic                       aclk             = 1'b0;
    logic                       aresetn          = 1'b0;
    logic                       cfg_valid        = 1'b0;
    logic                       cfg_ready;
    logic [LEN_W-1:0]           cfg_in_block_len = '0;
    logic                       s_valid          = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_i       = '0;
    logic signed [SAMPLE_W-1:0] s_sample_q       = '0;
    logic                       m_valid;
    logic                       m_ready          = 1'b0;
    logic signed [OUT_W-1:0]    m_out_i;
    logic signed [OUT_W-1:0]    m_out_q;
    logic                       m_block_end;

    resample_scoreboard sb;
    int s_idle_pct   = 0;
    int m_idle_pct   = 0;
    int stall_reqs   = 0;
    int stall_served = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    linear_interp_resampler_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_in_block_len (cfg_in_block_len),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_i       (s_sample_i),
        .s_sample_q       (s_sample_q),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_i          (m_out_i),
        .m_out_q          (m_out_q),
        .m_block_end      (m_block_end)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver with random stalls and an occasional long hold
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_reqs != stall_served) begin
            stall_served <= stall_reqs;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_len(cfg_in_block_len);
            if (s_valid && s_ready)
                sb.note_sample(s_sample_i, s_sample_q);
            if (m_valid && m_ready)
                sb.check_result(m_out_i, m_out_q, m_block_end);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a handshake", quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_part();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return SAMPLE_W'($urandom_range(7)) - 16'd4;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] si, input logic [SAMPLE_W-1:0] sq);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_valid    <= 1'b1;
        s_sample_i <= si;
        s_sample_q <= sq;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_block_len(input logic [LEN_W-1:0] v);
        cfg_valid        <= 1'b1;
        cfg_in_block_len <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [SAMPLE_W-1:0] dir_i[12];
        logic [SAMPLE_W-1:0] dir_q[12];
        logic [LEN_W-1:0]    phase_len[NUM_PHASES];

        dir_i = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                  16'h0001, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'h0000};
        dir_q = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                  16'hFFFF, 16'hAAAA, 16'h5555, 16'h7FFF, 16'h8000, 16'hFFFF};
        phase_len = '{15'd2048, 15'd2500, 15'd16384, 15'd0, 15'd32767, 15'd2047,
                      LEN_W'($urandom_range(16384, 2048)), LEN_W'($urandom_range(32767, 0)),
                      15'd2049};
        sb = new();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset rate, first sample primes the held value
        for (int k = 0; k < 12; k++)
            send_sample(dir_i[k], dir_q[k]);
        drain_results();
        // rate below range is clamped
        write_block_len(15'd0);
        for (int k = 0; k < 6; k++)
            send_sample(dir_i[k], dir_q[k]);
        drain_results();
        write_block_len(15'd32767);
        for (int k = 6; k < 12; k++)
            send_sample(dir_i[k], dir_q[k]);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 3)
                0: begin
                    s_idle_pct = 26;
                    m_idle_pct <= 56;
                end
                1: begin
                    s_idle_pct = 56;
                    m_idle_pct <= 26;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct <= 0;
                end
            endcase
            write_block_len(phase_len[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2 && (p == 0 || p == 4 || p == 7))
                    stall_reqs <= stall_reqs + 1;
                if (k == PHASE_ITEMS / 3 && p == 2)
                    drain_results();
                send_sample(rand_part(), rand_part());
            end
            drain_results();
        end

        // keep going at one output per request until the block count has wrapped
        write_block_len(15'd2048);
        while (sb.n_block_ends < 1)
            send_sample(rand_part(), rand_part());
        drain_results();

        $display("covered %0d requests over %0d rate settings, %0d results checked",
                 sb.n_samples, NUM_PHASES + 4, sb.n_checked);
        $display("block ends seen: %0d, errors: %0d, left pending: %0d",
                 sb.n_block_ends, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
